FILE: src/mlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg: shared definitions for the midpoint line rasterizer
// Command codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mlr_pkg;

	// fixed field widths
	localparam int PIX_BITS       = 13;
	localparam int ORIGIN_BITS    = 10;
	localparam int COLOR_BITS     = 4;
	localparam int CFG_INDEX_BITS = 2;

	// origin reset value, screen column and row
	localparam logic [ORIGIN_BITS-1:0] ORIGIN_RESET = 10'd320;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;

	// input command codes
	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

FILE: src/midpoint_line_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top: midpoint line rasterizer, all octants
// A start transaction latches a line and emits its first pixel; each advance
// transaction emits the next pixel, the final one flagged with last.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries command, the two Cartesian
//   endpoints and the colour. Output channel out_valid/out_ready carries one
//   pixel per start and per advance while a line is active; an advance with
//   no line in progress produces nothing.
//   Configuration: cfg_we writes cfg_data into origin_x (index 0) or
//   origin_y (index 1); other indexes are ignored.
//   Path: a transaction taken is captured in the input register, and its
//   pixel is registered from there into the output register.
//   Throughput: one transaction per cycle unless the output stalls, set by
//   the single error update (add and compare) between the two registers.
//   Reset: no line in progress, both origins at 320, both channels empty.
//   Stall: while out_ready is low the pixel holds; one more transaction is
//   taken into the input register, then in_ready falls until the pixel
//   is taken.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top #(
	parameter int COORD_BITS = 12
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration port
	input  wire                                    cfg_we,
	input  wire  [mlr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire  [mlr_pkg::ORIGIN_BITS-1:0]        cfg_data,
	// input channel
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire                                    command,
	input  wire  signed [COORD_BITS-1:0]           start_x,
	input  wire  signed [COORD_BITS-1:0]           start_y,
	input  wire  signed [COORD_BITS-1:0]           end_x,
	input  wire  signed [COORD_BITS-1:0]           end_y,
	input  wire  [mlr_pkg::COLOR_BITS-1:0]         color,
	// output channel
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [mlr_pkg::PIX_BITS-1:0]    pix_x,
	output logic signed [mlr_pkg::PIX_BITS-1:0]    pix_y,
	output logic [mlr_pkg::COLOR_BITS-1:0]         pix_color,
	output logic                                   last
);
	import mlr_pkg::*;

	// difference, error and wide screen widths
	localparam int DW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;
	localparam int WW = ((COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS) + 1;

	// configuration registers
	logic [ORIGIN_BITS-1:0] origin_x_q, origin_y_q;

	// input register
	logic                          valid_s1;
	logic                          command_s1;
	logic signed [COORD_BITS-1:0]  start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic [COLOR_BITS-1:0]         color_s1;

	// line state
	logic                  active_q;
	logic [PIX_BITS-1:0]   cur_x_q, cur_y_q;
	logic [DW-1:0]         remaining_q;
	logic signed [EW-1:0]  error_q;
	logic signed [EW-1:0]  two_minor_q;
	logic signed [EW-1:0]  diag_inc_q;
	logic                  steep_q;
	logic                  minor_neg_q;
	logic [COLOR_BITS-1:0] line_color_q;

	// output register
	logic                  out_valid_q;
	logic [PIX_BITS-1:0]   pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0] pix_color_q;
	logic                  last_q;

	// start path signals
	logic signed [WW-1:0]  sx_w, sy_w, ex_w, ey_w, ox_w, oy_w;
	logic signed [WW-1:0]  ax_w, ay_w, bx_w, by_w;
	logic signed [DW-1:0]  dx, dy;
	logic [DW-1:0]         adx, ady;
	logic                  st_steep, st_swap, st_minor_neg;
	logic [DW-1:0]         st_major, st_minor;
	logic signed [EW-1:0]  st_two_minor, st_two_major, st_error;

	// advance path signals
	logic                  adv_diag;
	logic [PIX_BITS-1:0]   minor_step;

	// next values
	logic                  fire, produce, is_start;
	logic [PIX_BITS-1:0]   nxt_x, nxt_y;
	logic [DW-1:0]         nxt_rem;
	logic signed [EW-1:0]  nxt_error;

	// handshake
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign is_start = (command_s1 == CMD_START);
	assign produce  = is_start || active_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_RESET;
			origin_y_q <= ORIGIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ORIGIN_X) begin
				origin_x_q <= cfg_data;
			end else if (cfg_index == CFG_ORIGIN_Y) begin
				origin_y_q <= cfg_data;
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
			color_s1   <= color;
		end
	end

	// endpoints to screen space, wrapped to pixel width
	always_comb begin
		sx_w = WW'(start_x_s1);
		sy_w = WW'(start_y_s1);
		ex_w = WW'(end_x_s1);
		ey_w = WW'(end_y_s1);
		ox_w = WW'(origin_x_q);
		oy_w = WW'(origin_y_q);
		ax_w = ox_w + sx_w;
		ay_w = oy_w - sy_w;
		bx_w = ox_w + ex_w;
		by_w = oy_w - ey_w;
	end

	// line setup: direction, octant and initial decision value
	always_comb begin
		dx           = DW'(end_x_s1) - DW'(start_x_s1);
		dy           = DW'(start_y_s1) - DW'(end_y_s1);
		adx          = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
		ady          = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
		st_steep     = ady > adx;
		st_swap      = st_steep ? dy[DW-1] : dx[DW-1];
		st_major     = st_steep ? ady : adx;
		st_minor     = st_steep ? adx : ady;
		st_minor_neg = (st_minor != '0) && ((st_steep ? dx[DW-1] : dy[DW-1]) ^ st_swap);
		st_two_minor = $signed({1'b0, st_minor, 1'b0});
		st_two_major = $signed({1'b0, st_major, 1'b0});
		st_error     = st_two_minor - $signed({2'b00, st_major});
	end

	// one midpoint step along the major axis
	always_comb begin
		adv_diag   = error_q > 0;
		minor_step = adv_diag ? (minor_neg_q ? '1 : PIX_BITS'(1)) : '0;
		nxt_error  = error_q + (adv_diag ? diag_inc_q : two_minor_q);
	end

	// select start or advance values
	always_comb begin
		if (is_start) begin
			nxt_x   = st_swap ? bx_w[PIX_BITS-1:0] : ax_w[PIX_BITS-1:0];
			nxt_y   = st_swap ? by_w[PIX_BITS-1:0] : ay_w[PIX_BITS-1:0];
			nxt_rem = st_major;
		end else if (steep_q) begin
			nxt_x   = cur_x_q + minor_step;
			nxt_y   = cur_y_q + PIX_BITS'(1);
			nxt_rem = remaining_q - DW'(1);
		end else begin
			nxt_x   = cur_x_q + PIX_BITS'(1);
			nxt_y   = cur_y_q + minor_step;
			nxt_rem = remaining_q - DW'(1);
		end
	end

	// line activity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && produce) begin
				active_q <= (nxt_rem != '0);
			end
			if (fire) begin
				out_valid_q <= produce;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line state and pixel payload
	always_ff @(posedge clk) begin
		if (fire && produce) begin
			cur_x_q     <= nxt_x;
			cur_y_q     <= nxt_y;
			remaining_q <= nxt_rem;
			pix_x_q     <= nxt_x;
			pix_y_q     <= nxt_y;
			last_q      <= (nxt_rem == '0);
			if (is_start) begin
				error_q      <= st_error;
				two_minor_q  <= st_two_minor;
				diag_inc_q   <= st_two_minor - st_two_major;
				steep_q      <= st_steep;
				minor_neg_q  <= st_minor_neg;
				line_color_q <= color_s1;
				pix_color_q  <= color_s1;
			end else begin
				error_q     <= nxt_error;
				pix_color_q <= line_color_q;
			end
		end
	end

	// output ports
	assign out_valid = out_valid_q;
	assign pix_x     = $signed(pix_x_q);
	assign pix_y     = $signed(pix_y_q);
	assign pix_color = pix_color_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	// a line in progress always has pixels left to give
	a_active_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (remaining_q != '0))
		else $error("active line with no remaining pixels");

	// the final pixel closes the line
	a_last_closes_line: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && produce && (nxt_rem == '0)) |=> !active_q)
		else $error("line still active after its last pixel");

	// the decision value never exceeds twice the minor length
	a_error_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (error_q <= two_minor_q))
		else $error("decision value out of range");

	// a line only becomes active through a start transaction
	a_start_opens_line: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> $past(fire && is_start))
		else $error("line activated without a start");

	// an idle advance gives no pixel
	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_start && !active_q) |=> !out_valid_q)
		else $error("pixel produced by an idle advance");
`endif

endmodule
`default_nettype wire
